// ----- sv/trbd_pkg.sv -----
package trbd_pkg;

  // Ring geometry.
  localparam int unsigned LOG_DEPTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(LOG_DEPTH);

  // Counter and record widths.
  localparam int unsigned CNT_W     = 36;
  localparam int unsigned FLAG_W    = 6;
  localparam int unsigned LANE_W    = 24;
  localparam int unsigned NUM_LANES = 5;
  localparam int unsigned REC_W     = FLAG_W + NUM_LANES * LANE_W;
  localparam int unsigned LINE_W    = REC_W + CNT_W;
  localparam int unsigned LINE_LEN  = 28;
  localparam int unsigned POS_W     = $clog2(LINE_LEN);

  // A drain reports an error once the backlog reaches this level.
  localparam logic [CNT_W-1:0] BACKLOG_LIMIT = CNT_W'(LOG_DEPTH - 2);

  // Character and kind codes.
  localparam logic [6:0] CHAR_START = 7'h3E;
  localparam logic [6:0] CHAR_ZERO  = 7'h00;
  localparam logic       KIND_TEXT  = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;

  // Action codes; code 3 is ignored.
  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_DRAIN = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_ERROR
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  flags;
    logic [31:0] lane_a;
    logic [31:0] lane_b;
    logic [31:0] lane_c;
    logic [31:0] lane_d;
    logic [31:0] lane_e;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] character;
    logic       last_of_line;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic clear;
    logic drain;
    logic load;
    logic emit_char;
    logic emit_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic line_done;
  } sts_t;

  // Maps a 6-bit digit onto the base64 alphabet.
  function automatic logic [6:0] digit_char(input logic [5:0] six);
    logic [6:0] c;
    if (six < 6'd26) begin
      c = 7'h41 + {1'b0, six};
    end else if (six < 6'd52) begin
      c = 7'h61 + {1'b0, six - 6'd26};
    end else if (six < 6'd62) begin
      c = 7'h30 + {1'b0, six - 6'd52};
    end else if (six == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// ----- sv/trace_ring_base64_drain.sv -----
// Trace record ring with a base64 line encoder on its drain side.
// The input channel (in_valid_i/in_ready_o pair, in_item_i) takes one action per item:
// store a record, drain the oldest pending record, or clear both counters.
// The output channel (out_valid_o/out_ready_i, out_item_o) gives characters.
// Stores and clears do not leave the idle state; items of that kind are taken back to back.
// A drain that finds a backlog of LOG_DEPTH - 2 or more gives a single error item
// through the error state; an empty backlog gives nothing and the input stays ready.
// A normal drain reads the record RAM (a registered read) and then shifts
// out 28 characters, one per cycle while the output is not stalled; the next item
// is taken only after the last of them. The single character sequencer paces this.
// The input is not ready while a line is being sent; a stall on the output simply
// holds the character in the output register and pauses the sequencer.
// Reset clears both counters, the sequencer and the output valid. The record RAM
// is not cleared; only slots written since the last reset or clear are read.
module trace_ring_base64_drain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trbd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trbd_pkg::out_item_t out_item_o
);
  import trbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .action_i  (in_item_i.action),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  trbd_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- sv/trbd_ram.sv -----
module trbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/trbd_ctrl.sv -----
module trbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    action_i,
  output logic          in_ready_o,
  input  trbd_pkg::sts_t sts_i,
  output trbd_pkg::cmd_t cmd_o
);
  import trbd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && action_i == ACT_DRAIN) begin
          if (sts_i.full) begin
            state_d = ST_ERROR;
          end else if (!sts_i.empty) begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.line_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.store = accept && (action_i == ACT_STORE);
        cmd_o.clear = accept && (action_i == ACT_CLEAR);
        cmd_o.drain = accept && (action_i == ACT_DRAIN) && !sts_i.full && !sts_i.empty;
      end
      ST_FETCH: begin
        cmd_o.load = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit_char = sts_i.out_free;
      end
      ST_ERROR: begin
        cmd_o.emit_err = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/trbd_dpath.sv -----
module trbd_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trbd_pkg::in_item_t  in_item_i,
  input  trbd_pkg::cmd_t      cmd_i,
  output trbd_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trbd_pkg::out_item_t out_item_o
);
  import trbd_pkg::*;

  logic [CNT_W-1:0]  written_q, written_d;
  logic [CNT_W-1:0]  sent_q, sent_d;
  logic [ADDR_W-1:0] wr_slot_q, wr_slot_d;
  logic [ADDR_W-1:0] rd_slot_q, rd_slot_d;
  logic [CNT_W-1:0]  id_q;
  logic [LINE_W-1:0] line_q;
  logic [POS_W-1:0]  pos_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  logic [CNT_W-1:0]  backlog;
  logic [REC_W-1:0]  wr_rec;
  logic [REC_W-1:0]  rd_rec;
  logic              out_free;
  logic              out_load;

  // Backlog check for a drain.
  assign backlog = written_q - sent_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.emit_char || cmd_i.emit_err;

  assign sts_o.full      = (backlog >= BACKLOG_LIMIT);
  assign sts_o.empty     = (backlog == '0);
  assign sts_o.out_free  = out_free;
  assign sts_o.line_done = (pos_q == POS_W'(LINE_LEN - 1));

  // Record layout: lanes e..a above the kept flag bits.
  assign wr_rec = {in_item_i.lane_e[31:8], in_item_i.lane_d[31:8], in_item_i.lane_c[31:8],
                   in_item_i.lane_b[31:8], in_item_i.lane_a[31:8], in_item_i.flags[5:0]};

  trbd_ram #(
    .WIDTH(REC_W),
    .DEPTH(LOG_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(wr_slot_q),
    .wdata_i(wr_rec),
    .re_i   (cmd_i.drain),
    .raddr_i(rd_slot_q),
    .rdata_o(rd_rec)
  );

  // Counters and ring slots; a slot wraps with its ring or with its counter.
  always_comb begin
    written_d = written_q;
    sent_d    = sent_q;
    wr_slot_d = wr_slot_q;
    rd_slot_d = rd_slot_q;
    if (cmd_i.clear) begin
      written_d = '0;
      sent_d    = '0;
      wr_slot_d = '0;
      rd_slot_d = '0;
    end else begin
      if (cmd_i.store) begin
        written_d = written_q + CNT_W'(1);
        if (written_q == '1 || wr_slot_q == ADDR_W'(LOG_DEPTH - 1)) begin
          wr_slot_d = '0;
        end else begin
          wr_slot_d = wr_slot_q + ADDR_W'(1);
        end
      end
      if (cmd_i.drain) begin
        sent_d = sent_q + CNT_W'(1);
        if (sent_q == '1 || rd_slot_q == ADDR_W'(LOG_DEPTH - 1)) begin
          rd_slot_d = '0;
        end else begin
          rd_slot_d = rd_slot_q + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      sent_q    <= '0;
      wr_slot_q <= '0;
      rd_slot_q <= '0;
    end else begin
      written_q <= written_d;
      sent_q    <= sent_d;
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
    end
  end

  // Line shift register: digits leave from the low end, six bits at a time.
  always_ff @(posedge clk_i) begin
    if (cmd_i.drain) begin
      id_q <= sent_q;
    end
    if (cmd_i.load) begin
      line_q <= {rd_rec[REC_W-1:FLAG_W], id_q, rd_rec[FLAG_W-1:0]};
    end else if (cmd_i.emit_char && pos_q != '0) begin
      line_q <= {6'd0, line_q[LINE_W-1:6]};
    end
  end

  // Character position within the line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.load) begin
      pos_q <= '0;
    end else if (cmd_i.emit_char) begin
      pos_q <= pos_q + POS_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      out_item_q.kind         <= KIND_ERROR;
      out_item_q.character    <= CHAR_ZERO;
      out_item_q.last_of_line <= 1'b1;
    end else if (cmd_i.emit_char) begin
      out_item_q.kind         <= KIND_TEXT;
      out_item_q.character    <= (pos_q == '0) ? CHAR_START : digit_char(line_q[5:0]);
      out_item_q.last_of_line <= sts_o.line_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- sv/trbd_checker.sv -----
module trbd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input trbd_pkg::out_item_t out_item_o
);
  import trbd_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // An error item is a lone, empty, final item.
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_ERROR |->
      out_item_o.character == CHAR_ZERO && out_item_o.last_of_line)
    else $error("malformed error item");

  // No new action is taken in the middle of a line.
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_TEXT && !out_item_o.last_of_line |-> !in_ready_o)
    else $error("input ready in the middle of a line");

  // Every text character is the start mark or a base64 digit.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_TEXT |->
      out_item_o.character == CHAR_START || out_item_o.character == 7'h2B ||
      out_item_o.character == 7'h2F ||
      (out_item_o.character >= 7'h30 && out_item_o.character <= 7'h39) ||
      (out_item_o.character >= 7'h41 && out_item_o.character <= 7'h5A) ||
      (out_item_o.character >= 7'h61 && out_item_o.character <= 7'h7A))
    else $error("character outside the line alphabet");

endmodule

bind trace_ring_base64_drain trbd_checker u_trbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
